// File: sv/rrts_pkg.sv
// Shared types, codes and constants of the round-robin thread scheduler.
`default_nettype none

package rrts_pkg;

  localparam int SLOT_W     = 4;
  localparam int PRIO_W     = 8;
  localparam int OP_W       = 3;
  localparam int BST_W      = 2;
  localparam int ERR_W      = 2;
  localparam int STAT_W     = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int DQ_CMD_W   = 3;

  // opcodes
  localparam logic [OP_W-1:0] OP_START   = 3'd0;
  localparam logic [OP_W-1:0] OP_PREEMPT = 3'd1;
  localparam logic [OP_W-1:0] OP_YIELD   = 3'd2;
  localparam logic [OP_W-1:0] OP_BLOCK   = 3'd3;
  localparam logic [OP_W-1:0] OP_UNBLOCK = 3'd4;
  localparam logic [OP_W-1:0] OP_EXIT    = 3'd5;

  // slot status codes
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd0;
  localparam logic [STAT_W-1:0] ST_RUNNING = 3'd1;
  localparam logic [STAT_W-1:0] ST_READY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_BLOCKED = 3'd3;
  localparam logic [STAT_W-1:0] ST_WAITING = 3'd4;
  localparam logic [STAT_W-1:0] ST_HANGING = 3'd5;
  localparam logic [STAT_W-1:0] ST_DIED    = 3'd6;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
  localparam logic [ERR_W-1:0] ERR_BAD_STATE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL      = 2'd2;
  localparam logic [ERR_W-1:0] ERR_NO_RUN    = 2'd3;

  // highest legal block status (hanging)
  localparam logic [BST_W-1:0] BST_MAX = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_SLOT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAIN_PRIO = 1'd1;

  localparam logic [SLOT_W-1:0] IDLE_SLOT_RST = 4'd1;
  localparam logic [PRIO_W-1:0] MAIN_PRIO_RST = 8'd31;

  // deque cell commands
  localparam logic [DQ_CMD_W-1:0] DQ_HOLD      = 3'd0;
  localparam logic [DQ_CMD_W-1:0] DQ_PUSH_TAIL = 3'd1;
  localparam logic [DQ_CMD_W-1:0] DQ_PUSH_HEAD = 3'd2;
  localparam logic [DQ_CMD_W-1:0] DQ_POP       = 3'd3;
  localparam logic [DQ_CMD_W-1:0] DQ_MARK      = 3'd4;
  localparam logic [DQ_CMD_W-1:0] DQ_BUBBLE    = 3'd5;
  localparam logic [DQ_CMD_W-1:0] DQ_CLEAR     = 3'd6;

  typedef struct packed {
    logic [DQ_CMD_W-1:0] cmd;
    logic [SLOT_W-1:0]   value;
  } dq_ctrl_t;

  function automatic logic can_unblock(input logic [STAT_W-1:0] st);
    return (st == ST_BLOCKED) || (st == ST_WAITING) || (st == ST_HANGING);
  endfunction

endpackage

`default_nettype wire

// File: sv/rrts_if.sv
// Handshake channel interfaces: command, result and configuration write.
`default_nettype none

interface rrts_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::OP_W-1:0]     opcode;
  logic [rrts_pkg::SLOT_W-1:0]   thread_slot;
  logic [rrts_pkg::PRIO_W-1:0]   priority_req;
  logic [rrts_pkg::BST_W-1:0]    block_status;
  logic                          reschedule;

  modport source (output valid, opcode, thread_slot, priority_req, block_status, reschedule,
                  input ready);
  modport sink   (input valid, opcode, thread_slot, priority_req, block_status, reschedule,
                  output ready);
endinterface

interface rrts_res_if;
  logic                          valid;
  logic                          ready;
  logic [rrts_pkg::SLOT_W-1:0]   running_now;
  logic                          switched;
  logic [rrts_pkg::PRIO_W-1:0]   slice_ticks;
  logic [rrts_pkg::ERR_W-1:0]    error_code;

  modport source (output valid, running_now, switched, slice_ticks, error_code,
                  input ready);
  modport sink   (input valid, running_now, switched, slice_ticks, error_code,
                  output ready);
endinterface

interface rrts_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rrts_pkg::CFG_IDX_W-1:0]    index;
  logic [rrts_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/rrts_cell.sv
// One position of the ready deque: holds a slot number and a removal hole flag.
`default_nettype none

module rrts_cell #(
  parameter int DEPTH = 16,
  parameter int INDEX = 0
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire rrts_pkg::dq_ctrl_t              ctrl,
  input  wire logic [$clog2(DEPTH+1)-1:0]      count,
  input  wire logic [rrts_pkg::SLOT_W-1:0]     left_entry,
  input  wire logic [rrts_pkg::SLOT_W-1:0]     right_entry,
  input  wire logic                            left_hole,
  output logic [rrts_pkg::SLOT_W-1:0]          entry,
  output logic                                 hole,
  output logic                                 tail_hole
);

  localparam int CNT_W = $clog2(DEPTH+1);
  localparam logic [CNT_W-1:0] POS      = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] POS_NEXT = CNT_W'(INDEX + 1);

  logic occupied;

  assign occupied  = POS < count;
  assign tail_hole = hole && (POS_NEXT == count);

  // entry: no reset, positions at or past count are never looked at
  always_ff @(posedge clk) begin
    unique case (ctrl.cmd)
      rrts_pkg::DQ_PUSH_TAIL: begin
        if (POS == count) begin
          entry <= ctrl.value;
        end
      end
      rrts_pkg::DQ_PUSH_HEAD: entry <= left_entry;
      rrts_pkg::DQ_POP:       entry <= right_entry;
      rrts_pkg::DQ_BUBBLE: begin
        if (hole) begin
          entry <= right_entry;
        end
      end
      default: ;
    endcase
  end

  // hole marks the removed entry; it walks toward the tail one cell a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      hole <= 1'b0;
    end else begin
      unique case (ctrl.cmd)
        rrts_pkg::DQ_MARK:   hole <= occupied && (entry == ctrl.value);
        rrts_pkg::DQ_BUBBLE: hole <= left_hole;
        rrts_pkg::DQ_CLEAR:  hole <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/rrts_deque.sv
// Ready deque built as a row of shifting cells, with its fill count.
`default_nettype none

module rrts_deque #(
  parameter int DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rrts_pkg::dq_ctrl_t            ctrl,
  output logic [rrts_pkg::SLOT_W-1:0]        head,
  output logic                               full,
  output logic                               empty,
  output logic                               tail_hole,
  output logic                               any_hole
);

  localparam int CNT_W = $clog2(DEPTH+1);

  logic [CNT_W-1:0]          count;
  logic [rrts_pkg::SLOT_W-1:0] ent [DEPTH];
  logic [DEPTH-1:0]          holes;
  logic [DEPTH-1:0]          tails;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [rrts_pkg::SLOT_W-1:0] left_e;
    logic [rrts_pkg::SLOT_W-1:0] right_e;
    logic                        left_h;

    if (i == 0) begin : g_first
      // push at the head feeds the new slot in from the left edge
      assign left_e = ctrl.value;
      assign left_h = 1'b0;
    end else begin : g_rest
      assign left_e = ent[i-1];
      assign left_h = holes[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = ent[i];
    end else begin : g_inner
      assign right_e = ent[i+1];
    end

    rrts_cell #(
      .DEPTH (DEPTH),
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .count       (count),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_hole   (left_h),
      .entry       (ent[i]),
      .hole        (holes[i]),
      .tail_hole   (tails[i])
    );
  end

  assign head      = ent[0];
  assign full      = count == CNT_W'(DEPTH);
  assign empty     = count == '0;
  assign any_hole  = |holes;
  assign tail_hole = |tails;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (ctrl.cmd) inside
        rrts_pkg::DQ_PUSH_TAIL, rrts_pkg::DQ_PUSH_HEAD: count <= count + CNT_W'(1);
        rrts_pkg::DQ_POP, rrts_pkg::DQ_CLEAR:           count <= count - CNT_W'(1);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/round_robin_thread_scheduler.sv
// Top level of the round-robin thread scheduler: sequencer, slot tables, deque.
//
//   channel  dir  transfer payload
//   -------  ---  ------------------------------------------------------------
//   cmd      in   opcode, thread_slot, priority_req, block_status, reschedule
//   result   out  running_now, switched, slice_ticks, error_code
//   cfg      in   index (0 idle_slot, 1 main_priority), data
//
// One command at a time. Exit of a slot that sits in the ready deque first
// marks its entry, then bubbles the hole toward the tail past each deque
// entry behind it and drops it there.
// Sequencing is set by the status table's single registered read port, one
// lookup per step. Per-slot entries never written read their reset values
// through valid bits, so no clearing pass runs on reset. The result sits in
// an output register; a new command is taken while it waits, and only the
// next result's load stalls on result.ready.
`default_nettype none

module round_robin_thread_scheduler #(
  parameter int THREAD_SLOTS = 16
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rrts_cmd_if.sink    cmd,
  rrts_res_if.source  result,
  rrts_cfg_if.sink    cfg
);

  localparam int IDX_W = $clog2(THREAD_SLOTS);
  localparam int SLOT_W = rrts_pkg::SLOT_W;
  localparam int PRIO_W = rrts_pkg::PRIO_W;
  localparam int STAT_W = rrts_pkg::STAT_W;
  localparam int ERR_W  = rrts_pkg::ERR_W;

  // sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_CHECK      = 4'd1;
  localparam logic [3:0] PH_RESCHED_RD = 4'd2;
  localparam logic [3:0] PH_RESCHED    = 4'd3;
  localparam logic [3:0] PH_PICK       = 4'd4;
  localparam logic [3:0] PH_IDLE_CHK   = 4'd5;
  localparam logic [3:0] PH_COMPACT    = 4'd6;
  localparam logic [3:0] PH_FINISH     = 4'd7;
  localparam logic [3:0] PH_OUT        = 4'd8;

  logic [3:0] phase, phase_next;

  // latched command
  logic [rrts_pkg::OP_W-1:0]  op_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [PRIO_W-1:0]          preq_q;
  logic [rrts_pkg::BST_W-1:0] bst_q;
  logic                       resched_q;

  logic [ERR_W-1:0]  err_q, err_next;
  logic              sw_q, sw_next;
  logic [SLOT_W-1:0] running_slot, running_next;
  logic [SLOT_W-1:0] idle_slot;

  // result register
  logic              out_valid;
  logic [SLOT_W-1:0] out_running;
  logic              out_switched;
  logic [PRIO_W-1:0] out_ticks;
  logic [ERR_W-1:0]  out_err;
  logic              out_load;

  // status table: one write, one registered read
  logic [STAT_W-1:0]       st_mem [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] st_vld;
  logic                    st_we;
  logic [IDX_W-1:0]        st_waddr, st_raddr;
  logic [STAT_W-1:0]       st_wdata;
  logic [STAT_W-1:0]       st_rd_raw, st_rd;
  logic                    st_rd_vld, st_rd_zero;

  // priority table; the tick budget always equals the priority (reload on
  // every requeue, nothing counts down), so one table serves both
  logic [PRIO_W-1:0]       pr_mem [THREAD_SLOTS];
  logic [THREAD_SLOTS-1:0] pr_vld;
  logic                    pr_we, pr_we_start, cfg_prio_we;
  logic [IDX_W-1:0]        pr_waddr;
  logic [PRIO_W-1:0]       pr_wdata;
  logic [PRIO_W-1:0]       pr_rd_raw, pr_rd;
  logic                    pr_rd_vld, pr_rd_zero;

  rrts_pkg::dq_ctrl_t dq_ctrl;
  logic [SLOT_W-1:0]  dq_head;
  logic               dq_full, dq_empty, dq_tail_hole, dq_any_hole;

  logic             cmd_take;
  logic             slot_ok, idle_oob;
  logic [IDX_W-1:0] cur_idx, slot_idx, idle_idx;

  assign cmd.ready  = phase == PH_IDLE;
  assign cmd_take   = cmd.valid && cmd.ready;
  assign cfg.ready  = 1'b1;
  assign cfg_prio_we = cfg.valid && (cfg.index == rrts_pkg::CFG_MAIN_PRIO);

  assign cur_idx  = IDX_W'(running_slot);
  assign slot_idx = IDX_W'(slot_q);
  assign idle_idx = IDX_W'(idle_slot);
  assign slot_ok  = 32'(slot_q) < THREAD_SLOTS;
  assign idle_oob = 32'(idle_slot) >= THREAD_SLOTS;

  // unwritten entries: slot zero running with main priority, others empty
  assign st_rd = st_rd_vld ? st_rd_raw :
                 (st_rd_zero ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_EMPTY);
  assign pr_rd = pr_rd_vld ? pr_rd_raw :
                 (pr_rd_zero ? rrts_pkg::MAIN_PRIO_RST : '0);

  rrts_deque #(
    .DEPTH (THREAD_SLOTS)
  ) u_deque (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (dq_ctrl),
    .head      (dq_head),
    .full      (dq_full),
    .empty     (dq_empty),
    .tail_hole (dq_tail_hole),
    .any_hole  (dq_any_hole)
  );

  // ---------------------------------------------------------------------
  // Sequencer. Every status write lands at the end of its cycle; a status
  // read is always issued in a later cycle than any write it must observe.
  // ---------------------------------------------------------------------
  always_comb begin
    phase_next   = phase;
    dq_ctrl      = '{cmd: rrts_pkg::DQ_HOLD, value: '0};
    st_we        = 1'b0;
    st_waddr     = cur_idx;
    st_wdata     = rrts_pkg::ST_EMPTY;
    st_raddr     = cur_idx;
    pr_we_start  = 1'b0;
    running_next = running_slot;
    err_next     = err_q;
    sw_next      = sw_q;
    out_load     = 1'b0;

    unique case (phase)
      PH_IDLE: begin
        if (cmd.valid) begin
          err_next = rrts_pkg::ERR_OK;
          sw_next  = 1'b0;
          // look up the addressed slot, or the running one
          case (cmd.opcode) inside
            rrts_pkg::OP_START, rrts_pkg::OP_UNBLOCK, rrts_pkg::OP_EXIT:
              st_raddr = IDX_W'(cmd.thread_slot);
            default: st_raddr = cur_idx;
          endcase
          case (cmd.opcode) inside
            rrts_pkg::OP_PREEMPT: phase_next = PH_RESCHED;
            rrts_pkg::OP_START, rrts_pkg::OP_YIELD, rrts_pkg::OP_BLOCK,
            rrts_pkg::OP_UNBLOCK, rrts_pkg::OP_EXIT: phase_next = PH_CHECK;
            default: phase_next = PH_FINISH;   // unknown opcode: no effect
          endcase
        end
      end

      PH_CHECK: begin
        phase_next = PH_FINISH;
        case (op_q)
          rrts_pkg::OP_START: begin
            if (!slot_ok || !(st_rd == rrts_pkg::ST_EMPTY || st_rd == rrts_pkg::ST_DIED)) begin
              err_next = rrts_pkg::ERR_BAD_STATE;
            end else if (dq_full) begin
              err_next = rrts_pkg::ERR_FULL;
            end else begin
              dq_ctrl     = '{cmd: rrts_pkg::DQ_PUSH_TAIL, value: slot_q};
              st_we       = 1'b1;
              st_waddr    = slot_idx;
              st_wdata    = rrts_pkg::ST_READY;
              pr_we_start = 1'b1;
            end
          end
          rrts_pkg::OP_YIELD: begin
            if (st_rd != rrts_pkg::ST_RUNNING) begin
              err_next = rrts_pkg::ERR_BAD_STATE;
            end else if (dq_full) begin
              err_next = rrts_pkg::ERR_FULL;
            end else begin
              // queued as ready, so the reschedule skips the requeue
              dq_ctrl    = '{cmd: rrts_pkg::DQ_PUSH_TAIL, value: running_slot};
              st_we      = 1'b1;
              st_wdata   = rrts_pkg::ST_READY;
              phase_next = PH_PICK;
            end
          end
          rrts_pkg::OP_BLOCK: begin
            if (bst_q > rrts_pkg::BST_MAX || st_rd == rrts_pkg::ST_READY) begin
              err_next = rrts_pkg::ERR_BAD_STATE;
            end else begin
              st_we      = 1'b1;
              st_wdata   = rrts_pkg::ST_BLOCKED + STAT_W'(bst_q);
              phase_next = PH_PICK;
            end
          end
          rrts_pkg::OP_UNBLOCK: begin
            if (!slot_ok || !rrts_pkg::can_unblock(st_rd)) begin
              err_next = rrts_pkg::ERR_BAD_STATE;
            end else if (dq_full) begin
              err_next = rrts_pkg::ERR_FULL;
            end else begin
              dq_ctrl  = '{cmd: rrts_pkg::DQ_PUSH_HEAD, value: slot_q};
              st_we    = 1'b1;
              st_waddr = slot_idx;
              st_wdata = rrts_pkg::ST_READY;
            end
          end
          rrts_pkg::OP_EXIT: begin
            if (!slot_ok) begin
              err_next = rrts_pkg::ERR_BAD_STATE;
            end else begin
              st_we    = 1'b1;
              st_waddr = slot_idx;
              st_wdata = rrts_pkg::ST_DIED;
              if (st_rd == rrts_pkg::ST_READY) begin
                // mark its deque entry, then close the gap
                dq_ctrl    = '{cmd: rrts_pkg::DQ_MARK, value: slot_q};
                phase_next = PH_COMPACT;
              end else if (resched_q) begin
                phase_next = PH_RESCHED_RD;
              end
            end
          end
          default: ;
        endcase
      end

      PH_RESCHED_RD: begin
        st_raddr   = cur_idx;
        phase_next = PH_RESCHED;
      end

      PH_RESCHED: begin
        phase_next = PH_PICK;
        if (st_rd == rrts_pkg::ST_RUNNING) begin
          if (dq_full) begin
            err_next   = rrts_pkg::ERR_FULL;
            phase_next = PH_FINISH;
          end else begin
            dq_ctrl  = '{cmd: rrts_pkg::DQ_PUSH_TAIL, value: running_slot};
            st_we    = 1'b1;
            st_wdata = rrts_pkg::ST_READY;
          end
        end
      end

      PH_PICK: begin
        if (dq_empty) begin
          if (idle_oob) begin
            err_next   = rrts_pkg::ERR_NO_RUN;
            phase_next = PH_FINISH;
          end else begin
            st_raddr   = idle_idx;
            phase_next = PH_IDLE_CHK;
          end
        end else begin
          dq_ctrl      = '{cmd: rrts_pkg::DQ_POP, value: '0};
          st_we        = 1'b1;
          st_waddr     = IDX_W'(dq_head);
          st_wdata     = rrts_pkg::ST_RUNNING;
          running_next = dq_head;
          sw_next      = 1'b1;
          phase_next   = PH_FINISH;
        end
      end

      PH_IDLE_CHK: begin
        // pushing the idle slot to an empty deque and popping it nets out
        // to running it directly
        phase_next = PH_FINISH;
        if (rrts_pkg::can_unblock(st_rd)) begin
          st_we        = 1'b1;
          st_waddr     = idle_idx;
          st_wdata     = rrts_pkg::ST_RUNNING;
          running_next = idle_slot;
          sw_next      = 1'b1;
        end else begin
          err_next = rrts_pkg::ERR_NO_RUN;
        end
      end

      PH_COMPACT: begin
        if (dq_tail_hole) begin
          dq_ctrl    = '{cmd: rrts_pkg::DQ_CLEAR, value: '0};
          phase_next = resched_q ? PH_RESCHED_RD : PH_FINISH;
        end else if (dq_any_hole) begin
          dq_ctrl = '{cmd: rrts_pkg::DQ_BUBBLE, value: '0};
        end else begin
          phase_next = resched_q ? PH_RESCHED_RD : PH_FINISH;
        end
      end

      // priority read of the running slot registers at the end of this cycle
      PH_FINISH: phase_next = PH_OUT;

      PH_OUT: begin
        if (!out_valid || result.ready) begin
          out_load   = 1'b1;
          phase_next = PH_IDLE;
        end
      end

      default: phase_next = PH_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      running_slot <= '0;
      idle_slot    <= rrts_pkg::IDLE_SLOT_RST;
      st_vld       <= '0;
      pr_vld       <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      running_slot <= running_next;
      if (cfg.valid && cfg.index == rrts_pkg::CFG_IDLE_SLOT) begin
        idle_slot <= cfg.data[SLOT_W-1:0];
      end
      if (st_we) begin
        st_vld[st_waddr] <= 1'b1;
      end
      if (pr_we) begin
        pr_vld[pr_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // command payload and per-command flags
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      op_q      <= cmd.opcode;
      slot_q    <= cmd.thread_slot;
      preq_q    <= cmd.priority_req;
      bst_q     <= cmd.block_status;
      resched_q <= cmd.reschedule;
    end
    err_q <= err_next;
    sw_q  <= sw_next;
  end

  // status table
  always_ff @(posedge clk) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rd_raw  <= st_mem[st_raddr];
    st_rd_vld  <= st_vld[st_raddr];
    st_rd_zero <= st_raddr == '0;
  end

  // priority table; a main_priority write presets slot zero
  assign pr_we    = pr_we_start || cfg_prio_we;
  assign pr_waddr = cfg_prio_we ? '0 : slot_idx;
  assign pr_wdata = cfg_prio_we ? cfg.data[PRIO_W-1:0] : preq_q;

  always_ff @(posedge clk) begin
    if (pr_we) begin
      pr_mem[pr_waddr] <= pr_wdata;
    end
    pr_rd_raw  <= pr_mem[cur_idx];
    pr_rd_vld  <= pr_vld[cur_idx];
    pr_rd_zero <= cur_idx == '0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_running  <= running_slot;
      out_switched <= sw_q;
      out_ticks    <= pr_rd;
      out_err      <= err_q;
    end
  end

  assign result.valid       = out_valid;
  assign result.running_now = out_running;
  assign result.switched    = out_switched;
  assign result.slice_ticks = out_ticks;
  assign result.error_code  = out_err;

endmodule

`default_nettype wire
